/* hdl/bdh_pkg.sv */
// Shared constants and types for the button debounce and hold detector.
`default_nettype none

package bdh_pkg;

  // Default number of buttons and the fixed width of the per-button fields.
  localparam int NUM_BUTTONS_DEF = 7;
  localparam int EVT_W           = 7;

  // Counter widths and limits.
  localparam int FILT_W = 8;
  localparam int HOLD_W = 16;
  localparam logic [FILT_W-1:0] FILT_MAX = {FILT_W{1'b1}};
  localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

  // Configuration register reset values.
  localparam logic [FILT_W-1:0] ON_TH_RST   = 8'd2;
  localparam logic [HOLD_W-1:0] HOLD_TH_RST = 16'd96;

  // Configuration port layout and register indexes.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ON_TH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TH = 1'b1;

  // Input word command codes.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  // Per-button stimulus for one word.
  typedef struct packed {
    logic tick;      // sample tick is being applied
    logic edge_hit;  // edge word with this button's flag set
    logic level;     // button is down (tick only)
  } bdh_cell_in_t;

  // Per-button results for one word.
  typedef struct packed {
    logic press_ev;
    logic hold_ev;
    logic rel_ev;
    logic went_off;
    logic is_off;    // phase after this word is off
  } bdh_cell_out_t;

endpackage

`default_nettype wire

/* hdl/bdh_button.sv */
// One button: filter count, phase and hold counter with their update logic.
`default_nettype none

module bdh_button (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [bdh_pkg::FILT_W-1:0] on_th,
  input  wire logic [bdh_pkg::HOLD_W-1:0] hold_th,
  input  wire bdh_pkg::bdh_cell_in_t      cell_in,
  output bdh_pkg::bdh_cell_out_t          cell_out
);

  typedef enum logic [1:0] {
    PH_OFF,
    PH_DEBOUNCE,
    PH_PRESSED,
    PH_HOLD
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic [bdh_pkg::FILT_W-1:0]   filt_r, filt_nxt;
  logic [bdh_pkg::HOLD_W-1:0]   hold_r, hold_nxt;
  logic [bdh_pkg::FILT_W-1:0]   filt_inc;
  logic [bdh_pkg::HOLD_W-1:0]   hold_inc;

  // Saturating filter increment and plain hold increment.
  assign filt_inc = (filt_r == bdh_pkg::FILT_MAX) ? filt_r : filt_r + 1'b1;
  assign hold_inc = hold_r + 1'b1;

  // Next state and events for this word.
  always_comb begin
    phase_nxt = phase_r;
    filt_nxt  = filt_r;
    hold_nxt  = hold_r;
    cell_out  = '0;
    if (cell_in.edge_hit && (phase_r == PH_OFF)) begin
      phase_nxt = PH_DEBOUNCE;
    end else if (cell_in.tick && (phase_r != PH_OFF)) begin
      if (cell_in.level) begin
        if (phase_r == PH_DEBOUNCE) begin
          filt_nxt = filt_inc;
          if (filt_inc >= on_th) begin
            phase_nxt         = PH_PRESSED;
            cell_out.press_ev = 1'b1;
          end
        end else if (hold_r != bdh_pkg::HOLD_MAX) begin
          hold_nxt = hold_inc;
          if (hold_inc == hold_th) begin
            phase_nxt        = PH_HOLD;
            cell_out.hold_ev = 1'b1;
          end
        end
      end else if (filt_r != '0) begin
        filt_nxt = filt_r - 1'b1;
        if (filt_r == {{(bdh_pkg::FILT_W-1){1'b0}}, 1'b1}) begin
          cell_out.rel_ev   = (phase_r == PH_PRESSED);
          phase_nxt         = PH_OFF;
          hold_nxt          = '0;
          cell_out.went_off = 1'b1;
        end
      end
    end
    cell_out.is_off = (phase_nxt == PH_OFF);
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OFF;
      filt_r  <= '0;
      hold_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      filt_r  <= filt_nxt;
      hold_r  <= hold_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/button_debounce_hold_detector.sv */
// Top level: input register, per-button cells, result register and config registers.
// Usage:
//   in_*  : one word per button event. in_cmd selects a sample tick (levels in
//           in_pressed_levels) or an edge word (flags in in_edge_flags).
//   out_* : exactly one result word per input word, in order, carrying the
//           press, hold and release bit masks and the timer start/stop pulses.
//   cfg_* : register writes (index 0 on threshold, index 1 hold threshold),
//           always ready; write them only while no word is in flight.
// An accepted word waits in the input register until the result register is
// free, and then the button logic's output for it is loaded into the result
// register. Throughput is one word per cycle while the receiver does not
// stall; the button state is updated at the same edge that loads the result
// register, so the next word sees it directly.
// Reset clears all buttons to off with zero counters, restores the register
// defaults and empties both pipeline registers.
// When the receiver stalls, the result register holds its word, the input
// register holds the next one, and in_ready drops only once both are full.
`default_nettype none

module button_debounce_hold_detector #(
  parameter int NUM_BUTTONS = bdh_pkg::NUM_BUTTONS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_cmd,
  input  wire logic [bdh_pkg::EVT_W-1:0]      in_pressed_levels,
  input  wire logic [bdh_pkg::EVT_W-1:0]      in_edge_flags,
  // Result channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [bdh_pkg::EVT_W-1:0]           out_press_events,
  output logic [bdh_pkg::EVT_W-1:0]           out_hold_events,
  output logic [bdh_pkg::EVT_W-1:0]           out_release_events,
  output logic                                out_timer_start,
  output logic                                out_timer_stop,
  // Configuration port
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bdh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bdh_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Buttons beyond the field width never see a flag, so they stay off.
  localparam int NB = (NUM_BUTTONS < bdh_pkg::EVT_W) ? NUM_BUTTONS : bdh_pkg::EVT_W;

  logic [bdh_pkg::FILT_W-1:0] on_th_r;
  logic [bdh_pkg::HOLD_W-1:0] hold_th_r;

  logic                       s1_valid_r;
  logic                       s1_cmd_r;
  logic [bdh_pkg::EVT_W-1:0]  s1_levels_r;
  logic [bdh_pkg::EVT_W-1:0]  s1_flags_r;
  logic                       adv;

  logic                       out_valid_r;
  logic [bdh_pkg::EVT_W-1:0]  press_r, hold_ev_r, rel_r;
  logic [bdh_pkg::EVT_W-1:0]  press_nxt, hold_ev_nxt, rel_nxt;
  logic                       tstart_r, tstop_r, tstart_nxt, tstop_nxt;

  bdh_pkg::bdh_cell_in_t      cell_in  [NB];
  bdh_pkg::bdh_cell_out_t     cell_out [NB];
  logic [NB-1:0]              went_off_v;
  logic [NB-1:0]              is_off_v;
  logic                       is_tick, is_edge;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_th_r   <= bdh_pkg::ON_TH_RST;
      hold_th_r <= bdh_pkg::HOLD_TH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bdh_pkg::REG_ON_TH:   on_th_r   <= cfg_data[bdh_pkg::FILT_W-1:0];
        bdh_pkg::REG_HOLD_TH: hold_th_r <= cfg_data[bdh_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on when the result register is free.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd_r    <= in_cmd;
      s1_levels_r <= in_pressed_levels;
      s1_flags_r  <= in_edge_flags;
    end
  end

  assign is_tick = s1_valid_r && adv && (s1_cmd_r == bdh_pkg::CMD_TICK);
  assign is_edge = s1_valid_r && adv && (s1_cmd_r == bdh_pkg::CMD_EDGE);

  // Button cells.
  for (genvar b = 0; b < NB; b++) begin : g_btn
    assign cell_in[b].tick     = is_tick;
    assign cell_in[b].edge_hit = is_edge && s1_flags_r[b];
    assign cell_in[b].level    = s1_levels_r[b];

    bdh_button u_btn (
      .clk      (clk),
      .rst_n    (rst_n),
      .on_th    (on_th_r),
      .hold_th  (hold_th_r),
      .cell_in  (cell_in[b]),
      .cell_out (cell_out[b])
    );

    assign went_off_v[b] = cell_out[b].went_off;
    assign is_off_v[b]   = cell_out[b].is_off;
  end

  // Gather the event masks; bits without a button stay zero.
  for (genvar j = 0; j < bdh_pkg::EVT_W; j++) begin : g_evt
    if (j < NB) begin : g_on
      assign press_nxt[j]   = cell_out[j].press_ev;
      assign hold_ev_nxt[j] = cell_out[j].hold_ev;
      assign rel_nxt[j]     = cell_out[j].rel_ev;
    end else begin : g_none
      assign press_nxt[j]   = 1'b0;
      assign hold_ev_nxt[j] = 1'b0;
      assign rel_nxt[j]     = 1'b0;
    end
  end

  assign tstart_nxt = (s1_cmd_r == bdh_pkg::CMD_EDGE) && (|s1_flags_r[NB-1:0]);
  assign tstop_nxt  = (s1_cmd_r == bdh_pkg::CMD_TICK) && (|went_off_v) && (&is_off_v);

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      press_r   <= press_nxt;
      hold_ev_r <= hold_ev_nxt;
      rel_r     <= rel_nxt;
      tstart_r  <= tstart_nxt;
      tstop_r   <= tstop_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_press_events   = press_r;
  assign out_hold_events    = hold_ev_r;
  assign out_release_events = rel_r;
  assign out_timer_start    = tstart_r;
  assign out_timer_stop     = tstop_r;

  // A word in the input register that advances must show up as a result.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv) |=> out_valid_r)
    else $error("advanced word did not reach the result register");

  // Edge words and ticks never produce each other's outputs.
  a_start_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_timer_start && out_timer_stop))
    else $error("timer start and stop in one word");

  a_edge_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_timer_start) |->
      (out_press_events == '0 && out_hold_events == '0 && out_release_events == '0))
    else $error("edge word carried button events");

  // A button cannot be pressed and released by the same tick.
  a_press_rel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_press_events & out_release_events) == '0))
    else $error("press and release on the same button");

endmodule

`default_nettype wire
